### hdl/ahs_pkg.sv
package ahs_pkg;

	// Fixed point format of factors and horizon fraction
	localparam int FRAC_BITS = 16;
	localparam logic [16:0] ONE = 17'h10000;
	localparam logic [16:0] HALF = 17'h08000;

	// Input commands
	localparam logic CMD_COMPUTE = 1'b0;
	localparam logic CMD_RESTART = 1'b1;

	// Configuration register indexes
	localparam logic [2:0] REG_HORIZON_MIN = 3'd0;
	localparam logic [2:0] REG_HORIZON_MAX = 3'd1;
	localparam logic [2:0] REG_WT_SPEED = 3'd2;
	localparam logic [2:0] REG_WT_OBSTACLE = 3'd3;
	localparam logic [2:0] REG_WT_ERROR = 3'd4;
	localparam logic [2:0] REG_OBSTACLE_THRESHOLD = 3'd5;
	localparam logic [2:0] REG_ERR_LIMIT = 3'd6;
	localparam logic [2:0] REG_EMA_ALPHA = 3'd7;

	// Reset values of the configuration registers
	localparam logic [7:0] RST_HORIZON_MIN = 8'd10;
	localparam logic [7:0] RST_HORIZON_MAX = 8'd50;
	localparam logic [7:0] RST_WEIGHT = 8'd1;
	localparam logic [15:0] RST_OBSTACLE_THRESHOLD = 16'd768;
	localparam logic [15:0] RST_ERR_LIMIT = 16'd256;
	localparam logic [16:0] RST_EMA_ALPHA = 17'd19661;

	typedef struct packed {
		logic [7:0] horizon_min;
		logic [7:0] horizon_max;
		logic [7:0] wt_speed;
		logic [7:0] wt_obstacle;
		logic [7:0] wt_error;
		logic [15:0] obstacle_threshold;
		logic [15:0] err_limit;
		logic [16:0] ema_alpha;
	} cfg_t;

	// Request to the serial divider: quotient of {rem0, low} / divisor,
	// one quotient bit per step, rem0 must be below divisor
	typedef struct packed {
		logic start;
		logic [4:0] steps;
		logic [15:0] rem0;
		logic [16:0] low;
		logic [15:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic [16:0] quot;
	} div_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FSTART,
		ST_FWAIT,
		ST_MUL,
		ST_ACC,
		ST_CDIV,
		ST_CWAIT,
		ST_RMUL,
		ST_RADD,
		ST_EMUL1,
		ST_EMUL2,
		ST_EADD,
		ST_RES
	} state_t;

endpackage

### hdl/adaptive_horizon_selector.sv
// Sequence: a restart item gives no result. A compute item is accepted only in idle, then
// takes per factor either a direct value or the serial divider (16 steps); then the
// weighted sum; then the average, direct or by the divider (17 steps); then scaling,
// smoothing and the result state, where it waits while the output is held.
// Throughput: one item at a time; input stalls until the result enters the output register.
// Reset: registers take their defaults, smoothing state is horizon_min, output empty.
module adaptive_horizon_selector
	import ahs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [2:0]  cfg_index,
	input  logic [16:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        command,
	input  logic [15:0] speed,
	input  logic [15:0] speed_limit,
	input  logic [15:0] obstacle_distance,
	input  logic [15:0] path_error,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  effective_horizon
);

	localparam logic [1:0] FAC_SPEED = 2'd0;
	localparam logic [1:0] FAC_OBST = 2'd1;
	localparam logic [1:0] FAC_ERR = 2'd2;

	cfg_t     cfg;
	div_req_t div_req;
	div_rsp_t div_rsp;
	state_t   state_q, state_d;

	// Control state
	logic [1:0]  fidx_q;
	logic        primed_q;
	logic [23:0] sm_q;
	logic        out_valid_q;

	// Payload
	logic [15:0] speed_q, limit_q, dist_q, err_q;
	logic [16:0] f_q [3];
	logic signed [42:0] prod_q;
	logic signed [42:0] acc_q;
	logic [16:0] comb_q;
	logic [23:0] raw_q;
	logic [7:0]  hor_q;

	logic        accept;
	logic        last_fac;
	logic [15:0] num_sel, den_sel;
	logic        fac_direct;
	logic [16:0] direct_val;
	logic [16:0] fac_div;
	logic [9:0]  w_total;
	logic [7:0]  w_sel;
	logic [16:0] alpha_c;
	logic signed [8:0] span;
	logic signed [17:0] mul_a;
	logic signed [24:0] mul_b;
	logic signed [42:0] mul_p;
	logic signed [42:0] raw_full;
	logic [42:0] ema_sum;
	logic [24:0] rnd;
	logic [8:0]  r9;
	logic [7:0]  r_lo;
	logic        out_free;

	ahs_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ahs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign last_fac = (fidx_q == FAC_ERR);
	assign out_free = !out_valid_q || !out_stall;

	// Operand selection for the factor divisions
	always_comb begin
		case (fidx_q)
			FAC_SPEED: begin
				num_sel = speed_q;
				den_sel = limit_q;
			end
			FAC_OBST: begin
				num_sel = dist_q;
				den_sel = cfg.obstacle_threshold;
			end
			default: begin
				num_sel = err_q;
				den_sel = cfg.err_limit;
			end
		endcase
	end

	// Zero threshold or saturated ratio needs no division
	always_comb begin
		fac_direct = (den_sel == 16'd0) || (num_sel >= den_sel);
		if (den_sel == 16'd0)
			direct_val = (fidx_q == FAC_SPEED) ? 17'd0 : ONE;
		else
			direct_val = (fidx_q == FAC_ERR) ? 17'd0 : ONE;
		fac_div = (fidx_q == FAC_ERR) ? (ONE - div_rsp.quot) : div_rsp.quot;
	end

	// Weights
	assign w_total = 10'(cfg.wt_speed) + 10'(cfg.wt_obstacle)
		+ 10'(cfg.wt_error);
	always_comb begin
		case (fidx_q)
			FAC_SPEED: w_sel = cfg.wt_speed;
			FAC_OBST: w_sel = cfg.wt_obstacle;
			default: w_sel = cfg.wt_error;
		endcase
	end

	assign alpha_c = (cfg.ema_alpha > ONE) ? ONE : cfg.ema_alpha;
	assign span = $signed({1'b0, cfg.horizon_max}) - $signed({1'b0, cfg.horizon_min});

	// Shared multiplier, operands by state
	always_comb begin
		case (state_q)
			ST_MUL: begin
				mul_a = $signed({10'd0, w_sel});
				mul_b = $signed({8'd0, f_q[fidx_q]});
			end
			ST_RMUL: begin
				mul_a = 18'(span);
				mul_b = $signed({8'd0, comb_q});
			end
			ST_EMUL1: begin
				mul_a = $signed({1'b0, alpha_c});
				mul_b = $signed({1'b0, raw_q});
			end
			ST_EMUL2: begin
				mul_a = $signed({1'b0, ONE - alpha_c});
				mul_b = $signed({1'b0, sm_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end
	assign mul_p = 43'(mul_a) * 43'(mul_b);

	assign raw_full = $signed({19'd0, cfg.horizon_min, 16'd0}) + prod_q;
	assign ema_sum = 43'(acc_q) + 43'(prod_q);

	// Round half up, then clamp to min and max
	assign rnd = {1'b0, sm_q} + 25'(HALF);
	assign r9 = rnd[24:16];
	assign r_lo = (r9 < {1'b0, cfg.horizon_min}) ? cfg.horizon_min : r9[7:0];

	// Divider requests
	always_comb begin
		div_req = '0;
		if (state_q == ST_FSTART && !fac_direct) begin
			div_req.start = 1'b1;
			div_req.steps = 5'd16;
			div_req.rem0 = num_sel;
			div_req.low = '0;
			div_req.divisor = den_sel;
		end else if (state_q == ST_CDIV && w_total != 10'd0) begin
			div_req.start = 1'b1;
			div_req.steps = 5'd17;
			div_req.rem0 = {7'd0, acc_q[25:17]};
			div_req.low = acc_q[16:0];
			div_req.divisor = {6'd0, w_total};
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:
				if (accept && command == CMD_COMPUTE)
					state_d = ST_FSTART;
			ST_FSTART:
				if (!fac_direct)
					state_d = ST_FWAIT;
				else if (last_fac)
					state_d = ST_MUL;
			ST_FWAIT:
				if (div_rsp.done)
					state_d = last_fac ? ST_MUL : ST_FSTART;
			ST_MUL: state_d = ST_ACC;
			ST_ACC: state_d = last_fac ? ST_CDIV : ST_MUL;
			ST_CDIV: state_d = (w_total == 10'd0) ? ST_RMUL : ST_CWAIT;
			ST_CWAIT:
				if (div_rsp.done)
					state_d = ST_RMUL;
			ST_RMUL: state_d = ST_RADD;
			ST_RADD: state_d = primed_q ? ST_EMUL1 : ST_RES;
			ST_EMUL1: state_d = ST_EMUL2;
			ST_EMUL2: state_d = ST_EADD;
			ST_EADD: state_d = ST_RES;
			ST_RES:
				if (out_free)
					state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fidx_q <= FAC_SPEED;
			primed_q <= 1'b0;
			sm_q <= {RST_HORIZON_MIN, 16'd0};
			out_valid_q <= 1'b0;
		end else begin
			// output register: loaded from the result state, emptied when taken
			if (state_q == ST_RES && out_free)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					fidx_q <= FAC_SPEED;
					if (accept && command == CMD_RESTART) begin
						sm_q <= {cfg.horizon_min, 16'd0};
						primed_q <= 1'b0;
					end
				end
				ST_FSTART:
					if (fac_direct)
						fidx_q <= last_fac ? FAC_SPEED : fidx_q + 2'd1;
				ST_FWAIT:
					if (div_rsp.done)
						fidx_q <= last_fac ? FAC_SPEED : fidx_q + 2'd1;
				ST_ACC: fidx_q <= last_fac ? FAC_SPEED : fidx_q + 2'd1;
				ST_RADD:
					if (!primed_q) begin
						sm_q <= raw_full[23:0];
						primed_q <= 1'b1;
					end
				ST_EADD: sm_q <= ema_sum[39:16];
				default: ;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE:
				if (accept) begin
					speed_q <= speed;
					limit_q <= speed_limit;
					dist_q <= obstacle_distance;
					err_q <= path_error;
					acc_q <= '0;
				end
			ST_FSTART:
				if (fac_direct)
					f_q[fidx_q] <= direct_val;
			ST_FWAIT:
				if (div_rsp.done)
					f_q[fidx_q] <= fac_div;
			ST_MUL: prod_q <= mul_p;
			ST_ACC: acc_q <= acc_q + prod_q;
			ST_CDIV:
				if (w_total == 10'd0)
					comb_q <= HALF;
			ST_CWAIT:
				if (div_rsp.done)
					comb_q <= div_rsp.quot;
			ST_RMUL: prod_q <= mul_p;
			ST_RADD: raw_q <= raw_full[23:0];
			ST_EMUL1: prod_q <= mul_p;
			ST_EMUL2: begin
				acc_q <= prod_q;
				prod_q <= mul_p;
			end
			ST_RES:
				if (out_free)
					hor_q <= (r_lo > cfg.horizon_max) ? cfg.horizon_max : r_lo;
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign effective_horizon = hor_q;

	// A restart leaves the filter unprimed at the current minimum
	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && command == CMD_RESTART) |=>
			(!primed_q && sm_q == {$past(cfg.horizon_min), 16'd0}))
		else $error("restart did not clear smoothing state");

	// Divider completes only while the sequencer waits for it
	a_div_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_FWAIT || state_q == ST_CWAIT))
		else $error("divider finished outside a wait state");

	// Factors are clamped to one before weighting
	a_factor_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |-> (f_q[fidx_q] <= ONE))
		else $error("factor above one");

	// A new result only comes from the result state
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_RES))
		else $error("result raised outside the result state");

endmodule

### hdl/ahs_cfg.sv
module ahs_cfg
	import ahs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [2:0]  cfg_index,
	input  logic [16:0] cfg_data,
	output cfg_t        cfg
);

	cfg_t cfg_q;

	// Register file, written by index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.horizon_min <= RST_HORIZON_MIN;
			cfg_q.horizon_max <= RST_HORIZON_MAX;
			cfg_q.wt_speed <= RST_WEIGHT;
			cfg_q.wt_obstacle <= RST_WEIGHT;
			cfg_q.wt_error <= RST_WEIGHT;
			cfg_q.obstacle_threshold <= RST_OBSTACLE_THRESHOLD;
			cfg_q.err_limit <= RST_ERR_LIMIT;
			cfg_q.ema_alpha <= RST_EMA_ALPHA;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_HORIZON_MIN: cfg_q.horizon_min <= cfg_data[7:0];
				REG_HORIZON_MAX: cfg_q.horizon_max <= cfg_data[7:0];
				REG_WT_SPEED: cfg_q.wt_speed <= cfg_data[7:0];
				REG_WT_OBSTACLE: cfg_q.wt_obstacle <= cfg_data[7:0];
				REG_WT_ERROR: cfg_q.wt_error <= cfg_data[7:0];
				REG_OBSTACLE_THRESHOLD: cfg_q.obstacle_threshold <= cfg_data[15:0];
				REG_ERR_LIMIT: cfg_q.err_limit <= cfg_data[15:0];
				REG_EMA_ALPHA: cfg_q.ema_alpha <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### hdl/ahs_div.sv
module ahs_div
	import ahs_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [15:0] rem_q;
	logic [16:0] low_q;
	logic [15:0] div_q;
	logic [16:0] quot_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;

	logic [16:0] trial;
	logic        fits;
	logic [16:0] diff;

	// One restoring step: shift in the next dividend bit, subtract if it fits
	assign trial = {rem_q, low_q[16]};
	assign fits = trial >= {1'b0, div_q};
	assign diff = trial - {1'b0, div_q};

	// Step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == 5'd1);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1)
					busy_q <= 1'b0;
			end
		end
	end

	// Remainder and quotient
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.rem0;
			low_q <= req.low;
			div_q <= req.divisor;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? diff[15:0] : trial[15:0];
			low_q <= {low_q[15:0], 1'b0};
			quot_q <= {quot_q[15:0], fits};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule
